// ===== hw/rtl/optt_pkg.sv =====
// Shared types and codes for the timer table.
// No dependencies; used by every file of the block but optt_free_find.
`timescale 1ns / 1ps

package optt_pkg;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_ONESHOT = 2'd1,
		MODE_REPEAT  = 2'd2,
		MODE_CANCEL  = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_STARTED = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DUR_W   = 24;
	localparam int unsigned IDENT_W = 16;

	// One slot of the table memory.
	typedef struct packed {
		logic               rep;
		logic [TIME_W-1:0]  deadline;
		logic [DUR_W-1:0]   interval;
		logic [IDENT_W-1:0] ident;
	} slot_t;

endpackage

// ===== hw/rtl/optt_req_if.sv =====
// Request channel of the timer table: valid/ready plus item payload.
// Depends on optt_pkg.
`timescale 1ns / 1ps

interface optt_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   mode;
	logic [optt_pkg::DUR_W-1:0]   duration;
	logic [optt_pkg::IDENT_W-1:0] cancel_id;

	modport source (output valid, mode, duration, cancel_id, input ready);
	modport sink (input valid, mode, duration, cancel_id, output ready);
endinterface

// ===== hw/rtl/optt_rsp_if.sv =====
// Result channel of the timer table: valid/ready plus result payload.
// Depends on optt_pkg.
`timescale 1ns / 1ps

interface optt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [optt_pkg::IDENT_W-1:0] timer_id;
	logic                         last;

	modport source (output valid, kind, timer_id, last, input ready);
	modport sink (input valid, kind, timer_id, last, output ready);
endinterface

// ===== hw/rtl/oneshot_periodic_timer_table.sv =====
// Timer table top level: sequencer, valid bits and result register.
// Depends on optt_pkg, optt_req_if, optt_rsp_if, optt_slot_mem, optt_free_find.
`timescale 1ns / 1ps

// A start item is answered in the cycle after it is taken and leaves the block
// in idle. Tick and cancel items walk the slot memory one slot per cycle
// through its single read port while the result side keeps up, then a flush
// step hands out a held expiry; each expiry after the first waits for the
// previous result to be taken. Expiries come out in slot order, the final
// result of an item carries last. No clearing pass is needed after reset:
// slot occupancy lives in flip-flops that reset clears.
module oneshot_periodic_timer_table #(
	parameter int unsigned SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	optt_req_if.sink    req,
	optt_rsp_if.source  rsp
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

	state_t                       state_q;
	logic [SLOTS-1:0]             valid_q;
	logic [optt_pkg::TIME_W-1:0]  now_q;
	logic [optt_pkg::IDENT_W-1:0] next_id_q;
	logic [optt_pkg::IDENT_W-1:0] cancel_q;
	logic                         tick_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         pend_q;
	logic [optt_pkg::IDENT_W-1:0] pend_id_q;
	logic                         rsp_valid_q;
	logic [1:0]                   rsp_kind_q;
	logic [optt_pkg::IDENT_W-1:0] rsp_id_q;
	logic                         rsp_last_q;

	logic                         acc;
	logic                         out_free;
	logic                         is_tick;
	logic                         is_cancel;
	logic                         is_start;
	logic                         free_found;
	logic [IDX_W-1:0]             free_idx;
	optt_pkg::slot_t              entry;
	logic [optt_pkg::TIME_W-1:0]  diff;
	logic                         slot_on;
	logic                         fire;
	logic                         hit;
	logic                         advance;
	logic                         last_slot;
	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	optt_pkg::slot_t              wr_data;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign is_tick   = req.mode == optt_pkg::MODE_TICK;
	assign is_cancel = req.mode == optt_pkg::MODE_CANCEL;
	assign is_start  = !is_tick && !is_cancel;

	optt_free_find #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_free (
		.valid (valid_q),
		.found (free_found),
		.idx   (free_idx)
	);

	// entry holds the slot at idx_q while scanning
	assign diff      = now_q - entry.deadline;
	assign slot_on   = valid_q[idx_q];
	assign fire      = tick_q && slot_on && !diff[optt_pkg::TIME_W-1];
	assign hit       = !tick_q && slot_on && (entry.ident == cancel_q);
	assign advance   = !(fire && pend_q && !out_free);
	assign last_slot = idx_q == IDX_W'(SLOTS - 1);

	assign rd_en   = (acc && !is_start) || (state_q == ST_SCAN && advance && !last_slot);
	assign rd_addr = acc ? '0 : IDX_W'(idx_q + 1'b1);

	always_comb begin
		if (state_q == ST_SCAN) begin
			wr_en            = fire && advance && entry.rep;
			wr_addr          = idx_q;
			wr_data          = entry;
			wr_data.deadline = entry.deadline + {8'd0, entry.interval};
		end else begin
			wr_en            = acc && is_start && free_found;
			wr_addr          = free_idx;
			wr_data.rep      = req.mode == optt_pkg::MODE_REPEAT;
			wr_data.deadline = now_q + {8'd0, req.duration};
			wr_data.interval = req.duration;
			wr_data.ident    = next_id_q;
		end
	end

	optt_slot_mem #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			now_q       <= '0;
			next_id_q   <= '0;
			cancel_q    <= '0;
			tick_q      <= 1'b0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_kind_q  <= optt_pkg::KIND_STARTED;
			rsp_id_q    <= '0;
			rsp_last_q  <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						priority if (is_tick) begin
							now_q   <= now_q + 1'b1;
							tick_q  <= 1'b1;
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else if (is_cancel) begin
							cancel_q <= req.cancel_id;
							tick_q   <= 1'b0;
							idx_q    <= '0;
							state_q  <= ST_SCAN;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_last_q  <= 1'b1;
							if (free_found) begin
								valid_q[free_idx] <= 1'b1;
								rsp_kind_q        <= optt_pkg::KIND_STARTED;
								rsp_id_q          <= next_id_q;
								next_id_q         <= next_id_q + 1'b1;
							end else begin
								rsp_kind_q <= optt_pkg::KIND_REJECT;
								rsp_id_q   <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (fire) begin
							// previous expiry is known not to be the last one
							if (pend_q) begin
								rsp_valid_q <= 1'b1;
								rsp_kind_q  <= optt_pkg::KIND_EXPIRED;
								rsp_id_q    <= pend_id_q;
								rsp_last_q  <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_id_q <= entry.ident;
							if (!entry.rep) begin
								valid_q[idx_q] <= 1'b0;
							end
						end
						if (hit) begin
							valid_q[idx_q] <= 1'b0;
						end
						if (last_slot) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= IDX_W'(idx_q + 1'b1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_kind_q  <= optt_pkg::KIND_EXPIRED;
						rsp_id_q    <= pend_id_q;
						rsp_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.kind     = rsp_kind_q;
	assign rsp.timer_id = rsp_id_q;
	assign rsp.last     = rsp_last_q;

	// a held expiry never survives into idle
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q != ST_IDLE)
		else $error("pending expiry left behind in idle");

	// a successful start occupies exactly one more slot
	a_start_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_start && free_found) |=>
		$countones(valid_q) == $countones($past(valid_q)) + 1)
		else $error("start did not occupy one slot");

	// start answers are always single results
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.kind != optt_pkg::KIND_EXPIRED) |-> rsp.last)
		else $error("start answer without last");

	// time moves by one per tick and only then
	a_now_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_tick) |=> now_q == $past(now_q) + 1'b1)
		else $error("time counter did not advance on tick");

	// no slot memory write outside a tick walk or a taken start
	a_wr_scope: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SCAN && tick_q) || (state_q == ST_IDLE && acc))
		else $error("stray slot memory write");

endmodule

// ===== hw/rtl/optt_slot_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on optt_pkg.
`timescale 1ns / 1ps

module optt_slot_mem #(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  optt_pkg::slot_t     wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output optt_pkg::slot_t     rd_data
);

	optt_pkg::slot_t mem [SLOTS];
	optt_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/optt_free_find.sv =====
// Lowest free slot search over the valid bits.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module optt_free_find #(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic [SLOTS-1:0] valid,
	output logic             found,
	output logic [IDX_W-1:0] idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== sim/timer_expiry_checker.sv =====
// Checker for the timer table: mirrors the slot table and compares every result.
// Depends on optt_pkg, optt_req_if and optt_rsp_if.
`timescale 1ns / 1ps

module timer_expiry_checker #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	optt_req_if                          req,
	optt_rsp_if                          rsp,
	output int                           fail_count,
	output int                           pending,
	output logic [optt_pkg::IDENT_W-1:0] next_id
);

	typedef struct packed {
		logic [1:0]                   kind;
		logic [optt_pkg::IDENT_W-1:0] timer_id;
		logic                         last;
	} timer_result_t;

	logic                         live [SLOTS];
	logic                         rep [SLOTS];
	logic [optt_pkg::TIME_W-1:0]  deadline [SLOTS];
	logic [optt_pkg::DUR_W-1:0]   interval [SLOTS];
	logic [optt_pkg::IDENT_W-1:0] ident [SLOTS];
	logic [optt_pkg::TIME_W-1:0]  now_ticks;
	timer_result_t                due_results [$];
	timer_result_t                want;

	task automatic expect_result(input logic [1:0] kind,
			input logic [optt_pkg::IDENT_W-1:0] id, input logic last);
		timer_result_t r;
		r.kind = kind;
		r.timer_id = id;
		r.last = last;
		due_results.insert(due_results.size(), r);
	endtask

	// Updates the mirrored table for one accepted request and queues its results.
	task automatic apply_request(input optt_pkg::mode_t m,
			input logic [optt_pkg::DUR_W-1:0] dur,
			input logic [optt_pkg::IDENT_W-1:0] cid);
		logic [optt_pkg::IDENT_W-1:0] fired [$];
		logic [optt_pkg::TIME_W-1:0]  diff;
		int                           free_slot;
		free_slot = -1;
		case (m)
			optt_pkg::MODE_TICK: begin
				now_ticks = now_ticks + 1;
				for (int i = 0; i < SLOTS; i++) begin
					if (live[i]) begin
						// wrap-safe: reached once the signed difference is not negative
						diff = now_ticks - deadline[i];
						if (!diff[optt_pkg::TIME_W-1]) begin
							fired.insert(fired.size(), ident[i]);
							if (rep[i])
								deadline[i] = deadline[i] + optt_pkg::TIME_W'(interval[i]);
							else
								live[i] = 1'b0;
						end
					end
				end
				foreach (fired[k])
					expect_result(optt_pkg::KIND_EXPIRED, fired[k], k == fired.size() - 1);
			end
			optt_pkg::MODE_CANCEL: begin
				for (int i = 0; i < SLOTS; i++)
					if (live[i] && ident[i] == cid)
						live[i] = 1'b0;
			end
			default: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!live[i])
						free_slot = i;
				if (free_slot < 0) begin
					expect_result(optt_pkg::KIND_REJECT, '0, 1'b1);
				end else begin
					live[free_slot] = 1'b1;
					rep[free_slot] = (m == optt_pkg::MODE_REPEAT);
					deadline[free_slot] = now_ticks + optt_pkg::TIME_W'(dur);
					interval[free_slot] = dur;
					ident[free_slot] = next_id;
					expect_result(optt_pkg::KIND_STARTED, next_id, 1'b1);
					next_id = next_id + 1'b1;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				live[i] = 1'b0;
			now_ticks = '0;
			next_id = '0;
			due_results.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// results of this edge belong to earlier requests, so check them first
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d timer_id %0d last %0d",
						rsp.kind, rsp.timer_id, rsp.last);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (rsp.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
						fail_count++;
					end
					if (rsp.timer_id !== want.timer_id) begin
						$error("timer_id: expected %0d, actual %0d", want.timer_id,
							rsp.timer_id);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, rsp.last);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				apply_request(optt_pkg::mode_t'(req.mode), req.duration, req.cancel_id);
			pending = due_results.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the timer table: clock, reset, request stimulus and verdict.
// Depends on optt_pkg, optt_req_if, optt_rsp_if, the block and timer_expiry_checker.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned SLOTS = 16;
	localparam int unsigned CYCLE_LIMIT = 100_000;
	localparam int unsigned DRAIN_CYCLES = 4 * (SLOTS + 2);
	localparam int unsigned RANDOM_ITEMS = 394;

	logic                         clk;
	logic                         arst_n;
	logic                         quiet;
	int                           fail_count;
	int                           pending;
	logic [optt_pkg::IDENT_W-1:0] next_id;
	logic [optt_pkg::IDENT_W-1:0] cid;
	int unsigned                  cycles = 0;
	int unsigned                  pick;

	optt_req_if req ();
	optt_rsp_if rsp ();

	oneshot_periodic_timer_table #(.SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	timer_expiry_checker #(.SLOTS(SLOTS)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.next_id    (next_id)
	);

	always #6 clk = ~clk;

	always @(negedge clk)
		rsp.ready <= quiet || ($urandom_range(99) >= 8);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic issue_request(input optt_pkg::mode_t m,
			input logic [optt_pkg::DUR_W-1:0] dur,
			input logic [optt_pkg::IDENT_W-1:0] id);
		while (!quiet && $urandom_range(99) < 8) begin
			req.valid <= 1'b0;
			req.mode <= optt_pkg::mode_t'($urandom_range(3));
			req.duration <= optt_pkg::DUR_W'($urandom);
			req.cancel_id <= optt_pkg::IDENT_W'($urandom);
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.duration <= dur;
		req.cancel_id <= id;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
	endtask

	// Mostly short delays so that expiries are frequent.
	function automatic logic [optt_pkg::DUR_W-1:0] pick_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return optt_pkg::DUR_W'($urandom_range(6));
		if (r < 88)
			return optt_pkg::DUR_W'($urandom_range(40, 7));
		return optt_pkg::DUR_W'($urandom);
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		req.valid = 1'b0;
		req.mode = optt_pkg::MODE_TICK;
		req.duration = '0;
		req.cancel_id = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero delays, cancels, full table, multi-expiry tick
		issue_request(optt_pkg::MODE_ONESHOT, '0, '0);
		issue_request(optt_pkg::MODE_TICK, '0, '0);
		issue_request(optt_pkg::MODE_REPEAT, '0, '1);
		issue_request(optt_pkg::MODE_TICK, '1, '1);
		issue_request(optt_pkg::MODE_TICK, '0, '0);
		issue_request(optt_pkg::MODE_CANCEL, '1, optt_pkg::IDENT_W'(1));
		issue_request(optt_pkg::MODE_CANCEL, '0, '1);
		issue_request(optt_pkg::MODE_ONESHOT, '1, '0);
		issue_request(optt_pkg::MODE_REPEAT, optt_pkg::DUR_W'(2), '0);
		for (int k = 0; k < SLOTS - 3; k++)
			issue_request(k[0] ? optt_pkg::MODE_REPEAT : optt_pkg::MODE_ONESHOT,
				optt_pkg::DUR_W'(1), '0);
		issue_request(optt_pkg::MODE_REPEAT, optt_pkg::DUR_W'(5), '0);
		issue_request(optt_pkg::MODE_ONESHOT, optt_pkg::DUR_W'(3), '0);
		issue_request(optt_pkg::MODE_TICK, '0, '0);
		issue_request(optt_pkg::MODE_CANCEL, '0, '0);
		issue_request(optt_pkg::MODE_TICK, '0, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet <= (n >= 150 && n < 260);
			pick = $urandom_range(99);
			if (pick < 35) begin
				issue_request(optt_pkg::MODE_TICK, optt_pkg::DUR_W'($urandom),
					optt_pkg::IDENT_W'($urandom));
			end else if (pick < 60) begin
				issue_request(optt_pkg::MODE_ONESHOT, pick_duration(),
					optt_pkg::IDENT_W'($urandom));
			end else if (pick < 80) begin
				issue_request(optt_pkg::MODE_REPEAT, pick_duration(),
					optt_pkg::IDENT_W'($urandom));
			end else begin
				// mostly recent ids, sometimes a random one
				if ($urandom_range(9) < 7)
					cid = next_id - optt_pkg::IDENT_W'(1)
						- optt_pkg::IDENT_W'($urandom_range(15));
				else
					cid = optt_pkg::IDENT_W'($urandom);
				issue_request(optt_pkg::MODE_CANCEL, optt_pkg::DUR_W'($urandom), cid);
			end
		end
		req.valid <= 1'b0;
		quiet <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== oneshot_periodic_timer_table.f =====
hw/rtl/optt_pkg.sv
hw/rtl/optt_req_if.sv
hw/rtl/optt_rsp_if.sv
hw/rtl/optt_slot_mem.sv
hw/rtl/optt_free_find.sv
hw/rtl/oneshot_periodic_timer_table.sv
sim/timer_expiry_checker.sv
sim/tb.sv
